### src/tcud_pkg.sv
package tcud_pkg;

  // code page selection held in the configuration register
  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_UTF8    = 2'd1,
    MODE_UTF16LE = 2'd2,
    MODE_UTF16BE = 2'd3
  } mode_t;

  localparam int unsigned CODE_W  = 31;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 3;

  // byte class boundaries for utf-8
  localparam logic [BYTE_W-1:0] CONT_LO  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD5_LO = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD6_LO = 8'hFC;
  localparam logic [BYTE_W-1:0] BAD_LO   = 8'hFE;

  localparam logic [COUNT_W-1:0] MAX_PENDING = 3'd5;

  // one input beat
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              block_start;
  } beat_t;

  // result of decoding one beat
  typedef struct packed {
    logic              emit;
    logic [CODE_W-1:0] value;
  } result_t;

endpackage

### src/tcud_in_reg.sv
module tcud_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcud_pkg::beat_t   in_beat,
  input  logic              advance,
  output logic              beat_valid,
  output tcud_pkg::beat_t   beat
);

  logic load;

  assign load     = in_valid && !in_stall;
  assign in_stall = beat_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (load) begin
      beat_valid <= 1'b1;
    end else if (advance) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat <= in_beat;
    end
  end

endmodule

### src/tcud_decode.sv
module tcud_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_write_data,
  input  logic                beat_valid,
  input  tcud_pkg::beat_t     beat,
  input  logic                advance,
  output tcud_pkg::result_t   result
);

  tcud_pkg::mode_t mode;

  logic [tcud_pkg::COUNT_W-1:0] pending_count;
  logic [tcud_pkg::CODE_W-1:0]  partial_code;
  logic [tcud_pkg::BYTE_W-1:0]  held_byte;
  logic                         byte_held;

  logic [tcud_pkg::COUNT_W-1:0] pending_count_next;
  logic [tcud_pkg::CODE_W-1:0]  partial_code_next;
  logic [tcud_pkg::BYTE_W-1:0]  held_byte_next;
  logic                         byte_held_next;

  logic [tcud_pkg::COUNT_W-1:0] pend_eff;
  logic [tcud_pkg::CODE_W-1:0]  part_eff;
  logic [tcud_pkg::BYTE_W-1:0]  held_eff;
  logic                         bheld_eff;
  logic [tcud_pkg::BYTE_W-1:0]  b;

  always_comb begin
    b         = beat.data_byte;
    // block start wipes any sequence in flight before this byte
    pend_eff  = beat.block_start ? '0 : pending_count;
    part_eff  = beat.block_start ? '0 : partial_code;
    held_eff  = beat.block_start ? '0 : held_byte;
    bheld_eff = beat.block_start ? 1'b0 : byte_held;

    pending_count_next = pend_eff;
    partial_code_next  = part_eff;
    held_byte_next     = held_eff;
    byte_held_next     = bheld_eff;
    result.emit        = 1'b0;
    result.value       = '0;

    unique case (mode)
      tcud_pkg::MODE_UTF8: begin
        priority if (b < tcud_pkg::CONT_LO) begin
          pending_count_next = '0;
          result.emit        = 1'b1;
          result.value       = {{(tcud_pkg::CODE_W-tcud_pkg::BYTE_W){1'b0}}, b};
        end else if (b < tcud_pkg::LEAD2_LO) begin
          // stray continuation is dropped
          if (pend_eff != '0) begin
            partial_code_next  = {part_eff[tcud_pkg::CODE_W-7:0], b[5:0]};
            pending_count_next = pend_eff - 3'd1;
            if (pend_eff == 3'd1) begin
              result.emit  = 1'b1;
              result.value = {part_eff[tcud_pkg::CODE_W-7:0], b[5:0]};
            end
          end
        end else if (b < tcud_pkg::LEAD3_LO) begin
          pending_count_next = 3'd1;
          partial_code_next  = {26'd0, b[4:0]};
        end else if (b < tcud_pkg::LEAD4_LO) begin
          pending_count_next = 3'd2;
          partial_code_next  = {27'd0, b[3:0]};
        end else if (b < tcud_pkg::LEAD5_LO) begin
          pending_count_next = 3'd3;
          partial_code_next  = {28'd0, b[2:0]};
        end else if (b < tcud_pkg::LEAD6_LO) begin
          pending_count_next = 3'd4;
          partial_code_next  = {29'd0, b[1:0]};
        end else if (b < tcud_pkg::BAD_LO) begin
          pending_count_next = tcud_pkg::MAX_PENDING;
          partial_code_next  = {30'd0, b[0]};
        end else begin
          // 0xfe and 0xff leave state alone
          pending_count_next = pend_eff;
        end
      end
      tcud_pkg::MODE_UTF16LE, tcud_pkg::MODE_UTF16BE: begin
        if (!bheld_eff) begin
          held_byte_next = b;
          byte_held_next = 1'b1;
        end else begin
          held_byte_next = '0;
          byte_held_next = 1'b0;
          result.emit    = 1'b1;
          if (mode == tcud_pkg::MODE_UTF16BE) begin
            result.value = {15'd0, held_eff, b};
          end else begin
            result.value = {15'd0, b, held_eff};
          end
        end
      end
      tcud_pkg::MODE_NONE: begin
        result.emit = 1'b0;
      end
      default: begin
        result.emit = 1'b0;
      end
    endcase

    if (!beat_valid) begin
      result.emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= tcud_pkg::MODE_UTF8;
      pending_count <= '0;
      partial_code  <= '0;
      held_byte     <= '0;
      byte_held     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        mode <= tcud_pkg::mode_t'(cfg_write_data);
      end
      if (advance) begin
        pending_count <= pending_count_next;
        partial_code  <= partial_code_next;
        held_byte     <= held_byte_next;
        byte_held     <= byte_held_next;
      end
    end
  end

  a_pending_max: assert property (@(posedge clk) disable iff (rst)
    pending_count <= tcud_pkg::MAX_PENDING)
    else $error("pending count above five");

  a_utf16_width: assert property (@(posedge clk) disable iff (rst)
    result.emit && (mode == tcud_pkg::MODE_UTF16LE || mode == tcud_pkg::MODE_UTF16BE)
    |-> result.value[tcud_pkg::CODE_W-1:16] == '0)
    else $error("utf-16 unit wider than 16 bits");

  a_stray_cont: assert property (@(posedge clk) disable iff (rst)
    beat_valid && beat.block_start && mode == tcud_pkg::MODE_UTF8
    && beat.data_byte >= tcud_pkg::CONT_LO && beat.data_byte < tcud_pkg::LEAD2_LO
    |-> !result.emit)
    else $error("continuation after block start produced a character");

  a_none_silent: assert property (@(posedge clk) disable iff (rst)
    mode == tcud_pkg::MODE_NONE |-> !result.emit)
    else $error("output in unsupported mode");

endmodule

### src/tcud_out_reg.sv
module tcud_out_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [tcud_pkg::CODE_W-1:0]  load_value,
  output logic                         out_free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcud_pkg::CODE_W-1:0]  code_value
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_value <= load_value;
    end
  end

endmodule

### src/text_code_unit_decoder.sv
// text code unit decoder: takes one text byte per beat and returns decoded
// character values for the code page in the mode register (0 none, 1 utf-8,
// 2 utf-16 little endian, 3 utf-16 big endian; utf-8 after reset). utf-8 is
// decoded leniently: stray continuations are dropped, 0xfe and 0xff are
// ignored, a new lead restarts the sequence, and an ascii byte cuts any open
// sequence short and comes out as itself. utf-16 pairs bytes into 16-bit
// units without joining surrogates. a byte with block_start set first clears
// any open sequence and any held byte. each byte gives zero or one result.
// throughput is one byte per clock unless a result is blocked by out_stall: the
// decode state (pending count, gathered bits, held byte) is updated from the
// input register, and the result lands in an output register. the input side
// keeps taking bytes while a result waits, as long as the byte in the input
// register produces nothing or the output register is draining. write the
// mode register only while the block is idle
module text_code_unit_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [1:0]                   cfg_write_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcud_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         block_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcud_pkg::CODE_W-1:0]  code_value
);

  tcud_pkg::beat_t   in_beat;
  tcud_pkg::beat_t   beat;
  tcud_pkg::result_t result;
  logic              beat_valid;
  logic              advance;
  logic              out_free;

  assign in_beat.data_byte   = data_byte;
  assign in_beat.block_start = block_start;

  // the byte in the input register retires when its result, if any, has room
  assign advance = beat_valid && (!result.emit || out_free);

  // input register
  tcud_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  // mode register, decode state and the per-byte decode logic
  tcud_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .beat_valid     (beat_valid),
    .beat           (beat),
    .advance        (advance),
    .result         (result)
  );

  // result register
  tcud_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && result.emit),
    .load_value (result.value),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_value (code_value)
  );

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> beat_valid && result.emit && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_value))
    else $error("waiting result lost");

endmodule

### tb/tb_text_code_unit_decoder.sv
`timescale 1ns / 100ps

module tb_text_code_unit_decoder;

  localparam int unsigned BYTE_W  = tcud_pkg::BYTE_W;
  localparam int unsigned CODE_W  = tcud_pkg::CODE_W;
  localparam int unsigned COUNT_W = tcud_pkg::COUNT_W;

  // ------------------------------------------------------------------
  // clock, reset and the ports of the block
  // ------------------------------------------------------------------
  logic              clk;
  logic              rst;
  logic              cfg_write_en;
  logic [1:0]        cfg_write_data;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] data_byte;
  logic              block_start;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CODE_W-1:0] code_value;

  text_code_unit_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .block_start    (block_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_value     (code_value)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case a beat or a result never shows up
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ------------------------------------------------------------------
  // decoder shadow: mode register plus the shared decode state
  // ------------------------------------------------------------------
  tcud_pkg::mode_t    cur_mode;
  logic [COUNT_W-1:0] seq_left;   // continuation bytes still owed (utf-8)
  logic [CODE_W-1:0]  seq_bits;   // code bits gathered so far (utf-8)
  logic [BYTE_W-1:0]  pair_first; // first byte of a utf-16 pair
  logic               pair_held;

  // code values still owed by the block, oldest first
  logic [CODE_W-1:0] expected_codes[$];
  int                mismatch_count = 0;
  int                items_counted;

  // works out what one byte does to the decode state and whether it emits
  task automatic decode_step(input logic [BYTE_W-1:0] b, input logic bs,
                             output logic emit, output logic [CODE_W-1:0] code);
    emit = 1'b0;
    code = '0;
    if (bs) begin
      seq_left   = '0;
      seq_bits   = '0;
      pair_first = '0;
      pair_held  = 1'b0;
    end
    case (cur_mode)
      tcud_pkg::MODE_UTF8: begin
        if (b < tcud_pkg::CONT_LO) begin
          // plain ascii, also cuts any open sequence short
          seq_left = '0;
          emit     = 1'b1;
          code     = CODE_W'(b);
        end else if (b < tcud_pkg::LEAD2_LO) begin
          // continuation, dropped when nothing is pending
          if (seq_left != 0) begin
            seq_bits = {seq_bits[CODE_W-7:0], b[5:0]};
            seq_left = seq_left - 1'b1;
            if (seq_left == 0) begin
              emit = 1'b1;
              code = seq_bits;
            end
          end
        end else if (b < tcud_pkg::LEAD3_LO) begin
          seq_left = 3'd1;
          seq_bits = CODE_W'(b[4:0]);
        end else if (b < tcud_pkg::LEAD4_LO) begin
          seq_left = 3'd2;
          seq_bits = CODE_W'(b[3:0]);
        end else if (b < tcud_pkg::LEAD5_LO) begin
          seq_left = 3'd3;
          seq_bits = CODE_W'(b[2:0]);
        end else if (b < tcud_pkg::LEAD6_LO) begin
          seq_left = 3'd4;
          seq_bits = CODE_W'(b[1:0]);
        end else if (b < tcud_pkg::BAD_LO) begin
          seq_left = tcud_pkg::MAX_PENDING;
          seq_bits = CODE_W'(b[0]);
        end
        // 0xfe and 0xff leave everything alone
      end
      tcud_pkg::MODE_UTF16LE, tcud_pkg::MODE_UTF16BE: begin
        if (!pair_held) begin
          pair_first = b;
          pair_held  = 1'b1;
        end else begin
          emit = 1'b1;
          if (cur_mode == tcud_pkg::MODE_UTF16BE)
            code = CODE_W'({pair_first, b});
          else
            code = CODE_W'({b, pair_first});
          pair_first = '0;
          pair_held  = 1'b0;
        end
      end
      default: begin
        // unsupported code page swallows the byte
      end
    endcase
  endtask

  // ------------------------------------------------------------------
  // sender: bursts of beats with random gaps, gaps can be switched off
  // ------------------------------------------------------------------
  logic tx_gaps;
  int   burst_left;

  // typed rows carry their own expectation, everything else uses the shadow
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic bs,
                           input logic typed, input logic t_emit,
                           input logic [CODE_W-1:0] t_code);
    logic              emit;
    logic [CODE_W-1:0] code;
    int                gap;
    if (tx_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    data_byte   <= b;
    block_start <= bs;
    // beat goes in at the first edge without stall
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_step(b, bs, emit, code);
    if (typed) begin
      emit = t_emit;
      code = t_code;
    end
    if (emit) expected_codes.push_back(code);
    items_counted++;
  endtask

  task automatic send_random_flag(input logic [BYTE_W-1:0] b);
    send_byte(b, ($urandom_range(0, 15) == 0), 1'b0, 1'b0, '0);
  endtask

  // stop offering beats and let every owed result drain out, plus the
  // pipeline depth so a byte that emits nothing is out of the block too
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input tcud_pkg::mode_t m);
    wait_drained();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= m;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    cur_mode = m;
  endtask

  // one utf-8 character: mostly well formed, some cut short, some noise
  task automatic send_utf8_char();
    int                n;
    int                sent;
    int                pick;
    logic [BYTE_W-1:0] lead;
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      send_random_flag(BYTE_W'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 6);
      case (n)
        1:       lead = BYTE_W'($urandom_range(0, 8'h7F));
        2:       lead = 8'hC0 | BYTE_W'($urandom_range(0, 8'h1F));
        3:       lead = 8'hE0 | BYTE_W'($urandom_range(0, 8'h0F));
        4:       lead = 8'hF0 | BYTE_W'($urandom_range(0, 8'h07));
        5:       lead = 8'hF8 | BYTE_W'($urandom_range(0, 8'h03));
        default: lead = 8'hFC | BYTE_W'($urandom_range(0, 8'h01));
      endcase
      send_random_flag(lead);
      // broken sequences lose some of their continuations
      sent = (pick >= 75) ? $urandom_range(0, n - 1) : n - 1;
      for (int i = 0; i < sent; i++)
        send_random_flag(8'h80 | BYTE_W'($urandom_range(0, 8'h3F)));
    end
  endtask

  // ------------------------------------------------------------------
  // receiver: stall pattern picked anew each time rx_count wraps, plus long holds
  // ------------------------------------------------------------------
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_style  = 0;
  int rx_count  = 0;

  always @(negedge clk) begin
    logic stall_now;
    if (hold_seen != hold_reqs) begin
      hold_left = 300;
      hold_seen = hold_reqs;
    end
    if (rx_count == 0) rx_style = $urandom_range(0, 3);
    rx_count = (rx_count + 1) % 64;
    if (hold_left > 0) begin
      hold_left--;
      stall_now = 1'b1;
    end else begin
      case (rx_style)
        0:       stall_now = 1'b0;
        1:       stall_now = ($urandom_range(0, 2) == 0);
        2:       stall_now = rx_count[1];
        default: stall_now = ($urandom_range(0, 3) != 0);
      endcase
    end
    out_stall <= stall_now;
  end

  // ------------------------------------------------------------------
  // result checker: every beat out of the block against the oldest owed
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: code_value expected none got %h", $time, code_value);
        mismatch_count++;
      end else begin
        if (code_value !== expected_codes[0]) begin
          $display("%0t: code_value expected %h got %h", $time,
                   expected_codes[0], code_value);
          mismatch_count++;
        end
        void'(expected_codes.pop_front());
      end
    end
  end

  // ------------------------------------------------------------------
  // directed table: mode writes and bytes, some with typed expectations
  // ------------------------------------------------------------------
  typedef enum logic {ROW_MODE, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    tcud_pkg::mode_t   mode;
    logic [BYTE_W-1:0] b;
    logic              bs;
    logic              typed;
    logic              t_emit;
    logic [CODE_W-1:0] t_code;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(input row_kind_t kind, input tcud_pkg::mode_t mode,
                         input logic [BYTE_W-1:0] b, input logic bs,
                         input logic typed, input logic t_emit,
                         input logic [CODE_W-1:0] t_code);
    dir_row_t r;
    r.kind   = kind;
    r.mode   = mode;
    r.b      = b;
    r.bs     = bs;
    r.typed  = typed;
    r.t_emit = t_emit;
    r.t_code = t_code;
    dir_rows.push_back(r);
  endtask

  task automatic build_table();
    // utf-8 right after reset: ascii extremes
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'h00, 1'b0, 1'b1, 1'b1, 31'h0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'h7F, 1'b0, 1'b1, 1'b1, 31'h7F);
    // two byte character
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hC3, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hA9, 1'b0, 1'b0, 1'b0, '0);
    // stray continuation, then the two ignored bytes
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'h80, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hFE, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hFF, 1'b0, 1'b1, 1'b0, '0);
    // ascii in the middle of a sequence comes out as itself
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hE2, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'h41, 1'b0, 1'b1, 1'b1, 31'h41);
    // new lead mid sequence restarts it
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hF0, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hE2, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'h82, 1'b0, 1'b0, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hAC, 1'b0, 1'b0, 1'b0, '0);
    // longest sequence gives the widest value
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hFD, 1'b0, 1'b1, 1'b0, '0);
    for (int i = 0; i < 4; i++)
      add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hBF, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hBF, 1'b0, 1'b1, 1'b1, 31'h7FFF_FFFF);
    // block start drops the open sequence, continuation turns stray
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hC3, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF8, 8'hA9, 1'b1, 1'b1, 1'b0, '0);
    // utf-16 little endian
    add_row(ROW_MODE, tcud_pkg::MODE_UTF16LE, '0, 1'b0, 1'b0, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF16LE, 8'h34, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF16LE, 8'h12, 1'b0, 1'b1, 1'b1, 31'h1234);
    // utf-16 big endian, block start drops the held byte
    add_row(ROW_MODE, tcud_pkg::MODE_UTF16BE, '0, 1'b0, 1'b0, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF16BE, 8'hFF, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF16BE, 8'hAB, 1'b1, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_UTF16BE, 8'hCD, 1'b0, 1'b1, 1'b1, 31'hABCD);
    // unsupported page emits nothing
    add_row(ROW_MODE, tcud_pkg::MODE_NONE, '0, 1'b0, 1'b0, 1'b0, '0);
    add_row(ROW_BYTE, tcud_pkg::MODE_NONE, 8'h41, 1'b0, 1'b1, 1'b0, '0);
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    int              phase_no;
    int              phase_len;
    int              waited;
    tcud_pkg::mode_t pm;
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    data_byte      = '0;
    block_start    = 1'b0;
    tx_gaps        = 1'b1;
    burst_left     = 0;
    items_counted  = 0;
    cur_mode       = tcud_pkg::MODE_UTF8;
    seq_left       = '0;
    seq_bits       = '0;
    pair_first     = '0;
    pair_held      = 1'b0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    build_table();
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_MODE)
        write_mode(dir_rows[i].mode);
      else
        send_byte(dir_rows[i].b, dir_rows[i].bs, dir_rows[i].typed,
                  dir_rows[i].t_emit, dir_rows[i].t_code);
    end

    // random phases; the decode state carries over across mode writes
    phase_no = 0;
    while (items_counted < 1050) begin
      if (phase_no < 4)
        pm = (phase_no == 0) ? tcud_pkg::MODE_UTF16LE :
             (phase_no == 1) ? tcud_pkg::MODE_UTF8 :
             (phase_no == 2) ? tcud_pkg::MODE_NONE : tcud_pkg::MODE_UTF16BE;
      else
        pm = tcud_pkg::mode_t'($urandom_range(0, 3));
      write_mode(pm);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      phase_len = (pm == tcud_pkg::MODE_NONE) ? 16 : $urandom_range(80, 130);
      // long receiver hold while the sender keeps pushing
      if (phase_no % 5 == 1) hold_reqs++;
      for (int k = 0; k < phase_len && items_counted < 1050; k++) begin
        // sender pause until the block has drained
        if (phase_no % 4 == 2 && k == phase_len / 2) wait_drained();
        if (pm == tcud_pkg::MODE_UTF8)
          send_utf8_char();
        else
          send_random_flag(BYTE_W'($urandom_range(0, 255)));
      end
      phase_no++;
    end

    // wind down
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_codes.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_codes.size() != 0) begin
      $display("%0t: code_value expected %h got none (%0d owed)", $time,
               expected_codes[0], expected_codes.size());
    end
    if (mismatch_count == 0 && expected_codes.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
